// File: sv/mcsq_pkg.sv
// Shared constants, codes and types of the maximum cardinality search queue.
package mcsq_pkg;

  // Sizes of the vertex store and of the item fields.
  localparam int MAX_VERTICES = 256;
  localparam int SLOTS        = 256;
  localparam int VTX_W        = 8;
  localparam int WGT_W        = 9;
  localparam int CNT_W        = 9;

  // One store entry: the weight in the low bits, the removed mark on top.
  localparam int ENTRY_W      = WGT_W + 1;

  // Item modes.
  localparam logic [1:0] MODE_RESTART = 2'd0;
  localparam logic [1:0] MODE_POP     = 2'd1;
  localparam logic [1:0] MODE_INC     = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_INC,
    ST_FINISH
  } state_t;

  // Control of the shared compare unit.
  typedef struct packed {
    logic clear;
    logic en;
    logic live;
  } amax_ctl_t;

endpackage

// File: sv/mcsq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: sv/mcsq_argmax.sv
// Shared compare unit: tracks the heaviest live vertex and the runner-up weight.
module mcsq_argmax (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mcsq_pkg::amax_ctl_t       ctl,
  input  logic [mcsq_pkg::WGT_W-1:0] weight,
  input  logic [mcsq_pkg::VTX_W-1:0] idx,
  output logic                      found,
  output logic [mcsq_pkg::VTX_W-1:0] best_idx,
  output logic [mcsq_pkg::WGT_W-1:0] best_w,
  output logic [mcsq_pkg::WGT_W-1:0] second_w
);
  import mcsq_pkg::*;

  logic             found_r, found_nxt;
  logic [VTX_W-1:0] best_idx_r, best_idx_nxt;
  logic [WGT_W-1:0] best_w_r, best_w_nxt;
  logic [WGT_W-1:0] second_w_r, second_w_nxt;

  // One element per cycle; only a strictly greater weight takes the lead, so
  // the lowest index wins a tie and an equal weight becomes the runner-up.
  always_comb begin
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_w_nxt   = best_w_r;
    second_w_nxt = second_w_r;
    if (ctl.clear) begin
      found_nxt    = 1'b0;
      second_w_nxt = '0;
    end else if (ctl.en && ctl.live) begin
      if (!found_r || (weight > best_w_r)) begin
        found_nxt    = 1'b1;
        best_idx_nxt = idx;
        best_w_nxt   = weight;
        if (found_r) begin
          second_w_nxt = best_w_r;
        end
      end else if (weight > second_w_r) begin
        second_w_nxt = weight;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      second_w_r <= '0;
    end else begin
      found_r    <= found_nxt;
      second_w_r <= second_w_nxt;
    end
    best_idx_r <= best_idx_nxt;
    best_w_r   <= best_w_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;
  assign best_w   = best_w_r;
  assign second_w = second_w_r;

  // The runner-up never outweighs the leader.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> (second_w_r <= best_w_r))
    else $error("runner-up weight above leader");

  // Without a leader there is no runner-up.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !found_r |-> (second_w_r == '0))
    else $error("runner-up weight without leader");

  // A live element seen after the clear always yields a leader.
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.en && ctl.live && !ctl.clear) |=> found_r)
    else $error("live element left no leader");

endmodule

// File: sv/max_cardinality_search_queue.sv
// Top level of the maximum cardinality search weight queue.
//
//  channel | direction | signals                      | contents (low bit up)
//  --------+-----------+------------------------------+------------------------------
//  in      | sink      | in_tvalid/in_tready/in_tdata | mode[1:0], vertex[9:2]
//  out     | source    | out_tvalid/out_tready/       | popped_vertex[7:0], error[9:8],
//          |           | out_tdata/out_tuser          | peak_weight[18:10], remaining[27:19];
//          |           |                              | tuser: pop_valid
//  cfg     | sink      | cfg_valid/cfg_ready/cfg_data | vertex_count[8:0]
//
// A restart, an unused mode or an out-of-range increment goes from idle to finish,
// other increments via the increment state, a non-empty pop via the scan, which walks
// the store (each vertex's weight and removed mark) one vertex per cycle through
// one shared compare unit. One item is in work at a time; a stalled result holds
// the sequencer in its last state and the next item is accepted once it is idle.
// The synchronous reset clears the queue as a restart with 256 vertices would;
// configuration writes are taken in every cycle.
module max_cardinality_search_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // mode[1:0], vertex[9:2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // popped_vertex[7:0], error[9:8], peak_weight[18:10],
                                  // remaining[27:19]
  output logic [0:0]  out_tuser,  // pop_valid[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data    // vertex_count[8:0]
);
  import mcsq_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   vcount_r, vcount_nxt;
  logic [CNT_W-1:0]   active_r, active_nxt;
  logic [CNT_W-1:0]   live_r, live_nxt;
  logic [WGT_W-1:0]   top_r, top_nxt;
  logic [SLOTS-1:0]   wvalid_r, wvalid_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [VTX_W-1:0]   cmp_idx_r, cmp_idx_nxt;
  logic [VTX_W-1:0]   vtx_r, vtx_nxt;
  logic [VTX_W-1:0]   res_pop_r, res_pop_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [1:0]         res_err_r, res_err_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [31:0]        out_tdata_r, out_tdata_nxt;
  logic [0:0]         out_tuser_r, out_tuser_nxt;

  logic               accept;
  logic [1:0]         in_mode;
  logic [VTX_W-1:0]   in_vertex;
  logic               out_free;
  logic               scan_done;
  logic [CNT_W-1:0]   clamped;
  logic [ENTRY_W-1:0] rd_data;
  logic [VTX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [VTX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               cur_removed;
  logic [WGT_W-1:0]   cur_w;
  logic [WGT_W-1:0]   inc_w;
  logic               cmp_removed;
  logic [WGT_W-1:0]   cmp_w;
  amax_ctl_t          amax_ctl;
  logic               am_found;
  logic [VTX_W-1:0]   am_best_idx;
  logic [WGT_W-1:0]   am_best_w;
  logic [WGT_W-1:0]   am_second_w;

  // Handshake and field decode.
  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign in_mode   = in_tdata[1:0];
  assign in_vertex = in_tdata[9:2];
  assign out_free  = !out_tvalid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign scan_done = (idx_r >= active_r) && !cmp_v_r;

  // Vertex count as applied at restart: zero acts as one, the store caps it.
  always_comb begin
    clamped = vcount_r;
    if (vcount_r == '0) begin
      clamped = CNT_W'(1);
    end else if (vcount_r > CNT_W'(SLOTS)) begin
      clamped = CNT_W'(SLOTS);
    end
  end

  // Vertex store; an entry without its written bit reads as weight zero, live.
  assign rd_addr     = (state_r == ST_IDLE) ? in_vertex : idx_r[VTX_W-1:0];
  assign cur_removed = wvalid_r[vtx_r] && rd_data[WGT_W];
  assign cur_w       = wvalid_r[vtx_r] ? rd_data[WGT_W-1:0] : '0;
  assign inc_w       = (cur_w < WGT_W'(MAX_VERTICES)) ? (cur_w + WGT_W'(1)) : cur_w;
  assign cmp_removed = wvalid_r[cmp_idx_r] && rd_data[WGT_W];
  assign cmp_w       = wvalid_r[cmp_idx_r] ? rd_data[WGT_W-1:0] : '0;

  // Store writes: an increment saves the new weight, a pop marks its vertex removed.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = vtx_r;
    wr_data = {1'b0, inc_w};
    if ((state_r == ST_INC) && !cur_removed) begin
      wr_en = 1'b1;
    end else if ((state_r == ST_SCAN) && scan_done && am_found) begin
      wr_en   = 1'b1;
      wr_addr = am_best_idx;
      wr_data = {1'b1, am_best_w};
    end
  end

  mcsq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_wgt_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Compare unit fed one stored vertex per cycle during a pop scan.
  always_comb begin
    amax_ctl.clear = accept && (in_mode == MODE_POP);
    amax_ctl.en    = cmp_v_r;
    amax_ctl.live  = !cmp_removed;
  end

  mcsq_argmax u_argmax (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (amax_ctl),
    .weight   (cmp_w),
    .idx      (cmp_idx_r),
    .found    (am_found),
    .best_idx (am_best_idx),
    .best_w   (am_best_w),
    .second_w (am_second_w)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_POP: begin
              state_nxt = (live_r == '0) ? ST_FINISH : ST_SCAN;
            end
            MODE_INC: begin
              if (CNT_W'(in_vertex) >= active_r) begin
                state_nxt = ST_FINISH;
              end else begin
                state_nxt = ST_INC;
              end
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_INC:    state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and queue state updates.
  always_comb begin
    vcount_nxt     = vcount_r;
    active_nxt     = active_r;
    live_nxt       = live_r;
    top_nxt        = top_r;
    wvalid_nxt     = wvalid_r;
    idx_nxt        = idx_r;
    cmp_v_nxt      = 1'b0;
    cmp_idx_nxt    = cmp_idx_r;
    vtx_nxt        = vtx_r;
    res_pop_nxt    = res_pop_r;
    res_valid_nxt  = res_valid_r;
    res_err_nxt    = res_err_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (cfg_valid && cfg_ready) begin
      vcount_nxt = cfg_data;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          vtx_nxt       = in_vertex;
          res_pop_nxt   = '0;
          res_valid_nxt = 1'b0;
          res_err_nxt   = ERR_NONE;
          case (in_mode)
            MODE_RESTART: begin
              wvalid_nxt  = '0;
              active_nxt  = clamped;
              live_nxt    = clamped;
              top_nxt     = '0;
            end
            MODE_POP: begin
              if (live_r == '0) begin
                res_err_nxt = ERR_EMPTY;
              end
              idx_nxt = '0;
            end
            MODE_INC: begin
              if (CNT_W'(in_vertex) >= active_r) begin
                res_err_nxt = ERR_RANGE;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        // Issue one read a cycle; the compare stage follows in the next cycle.
        if (idx_r < active_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = idx_r[VTX_W-1:0];
          idx_nxt     = idx_r + CNT_W'(1);
        end else if (scan_done && am_found) begin
          wvalid_nxt[am_best_idx] = 1'b1;
          live_nxt                = live_r - CNT_W'(1);
          top_nxt                 = am_second_w;
          res_pop_nxt             = am_best_idx;
          res_valid_nxt           = 1'b1;
        end
      end
      ST_INC: begin
        // A removed vertex keeps its weight.
        if (!cur_removed) begin
          wvalid_nxt[vtx_r] = 1'b1;
          if (inc_w > top_r) begin
            top_nxt = inc_w;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'd0, live_r, ((live_r == '0) ? WGT_W'(0) : top_r),
                            res_err_r, res_pop_r};
          out_tuser_nxt  = res_valid_r;
        end
      end
      default: ;
    endcase
  end

  // Registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      vcount_r     <= CNT_W'(SLOTS);
      active_r     <= CNT_W'(SLOTS);
      live_r       <= CNT_W'(SLOTS);
      top_r        <= '0;
      wvalid_r     <= '0;
      cmp_v_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      vcount_r     <= vcount_nxt;
      active_r     <= active_nxt;
      live_r       <= live_nxt;
      top_r        <= top_nxt;
      wvalid_r     <= wvalid_nxt;
      cmp_v_r      <= cmp_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    idx_r       <= idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    vtx_r       <= vtx_nxt;
    res_pop_r   <= res_pop_nxt;
    res_valid_r <= res_valid_nxt;
    res_err_r   <= res_err_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // The live count never exceeds the vertices in use.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= active_r)
    else $error("live count above vertices in use");

  // The vertices in use stay within the store.
  a_active: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r != '0) && (active_r <= CNT_W'(SLOTS)))
    else $error("vertex count out of range");

  // A pop scan only ends with a leader found, since it starts with live vertices.
  a_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN) && scan_done) |-> am_found)
    else $error("pop scan found no live vertex");

  // A finished item is only handed over once the result register is free.
  a_hand: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FINISH) && !out_free) |=> (state_r == ST_FINISH))
    else $error("result dropped while output stalled");

endmodule
